### sv/assert_macros.svh
// Assertion helpers for the tile map collision checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### sv/tmsc_pkg.sv
package tmsc_pkg;
   localparam int CRD_W = 24;
   localparam int AX_W  = 25;
   localparam int PT_W  = 28;
   localparam int PR_W  = PT_W + AX_W;
   localparam int SUM_W = PR_W + 1;
   localparam int QW    = 17;
   localparam int TSW   = 11;
   localparam int CNT_W = 7;
   localparam int ADR_W = 15;
   localparam int RW    = 18;

   localparam logic [3:0] CSR_ORIGIN_X = 4'd0;
   localparam logic [3:0] CSR_ORIGIN_Y = 4'd1;
   localparam logic [3:0] CSR_EXTENT_W = 4'd2;
   localparam logic [3:0] CSR_EXTENT_H = 4'd3;
   localparam logic [3:0] CSR_TILE_W   = 4'd4;
   localparam logic [3:0] CSR_TILE_H   = 4'd5;
   localparam logic [3:0] CSR_COLS     = 4'd6;
   localparam logic [3:0] CSR_ROWS     = 4'd7;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [7:0] CODE_WALKABLE = 8'd1;

   typedef logic signed [PR_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic           go;
      logic [QW-1:0]  dividend;
      logic [TSW-1:0] divisor;
   } div_req_type;
endpackage

### sv/tmsc_ram.sv
module tmsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/tmsc_mul.sv
module tmsc_mul (
   input  logic                                 clock,
   input  logic signed [tmsc_pkg::PT_W-1:0]     a,
   input  logic signed [tmsc_pkg::AX_W-1:0]     b,
   output tmsc_pkg::prod_type                   prod
);
   tmsc_pkg::prod_type prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;
endmodule

### sv/tmsc_div.sv
module tmsc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tmsc_pkg::div_req_type         req,
   output logic                          done,
   output logic [tmsc_pkg::QW-1:0]       quo
);
   logic                        run_ff;
   logic                        done_ff;
   logic [4:0]                  cnt_ff;
   logic [tmsc_pkg::QW-1:0]     quo_ff;
   logic [tmsc_pkg::TSW-1:0]    rem_ff;
   logic [tmsc_pkg::TSW-1:0]    dvs_ff;
   logic [tmsc_pkg::TSW:0]      rem_sh;
   logic                        qbit;
   logic [tmsc_pkg::TSW-1:0]    rem_in;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[tmsc_pkg::QW-1]};
      qbit   = rem_sh >= {1'b0, dvs_ff};
      rem_in = qbit ? tmsc_pkg::TSW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[tmsc_pkg::TSW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            quo_ff <= req.dividend;
            rem_ff <= '0;
            dvs_ff <= req.divisor;
         end else if (run_ff) begin
            quo_ff <= {quo_ff[tmsc_pkg::QW-2:0], qbit};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(tmsc_pkg::QW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

### sv/tile_map_sat_collision_top.sv
// Tile writes leave busy low; no result is returned.
// A query holds busy until it ends: early when the box misses the map or its tile range is empty,
// else after the four divisions, the box projection and a pass over its tiles, in which walkable
// tiles skip the axis test; the box projection and the tile tests share one multiplier.
// One query at a time; rsp_strobe pulses in the first cycle with busy low, no stall.
// Synchronous reset clears control and loads the register defaults; the tile store is not cleared.
module tile_map_sat_collision_top #(
   parameter int MAX_TILES = 4096,
   parameter int LAYERS    = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic signed [3:0]  req_layer,
   input  logic [11:0]        req_tile_index,
   input  logic [7:0]         req_tile_code,
   input  logic signed [23:0] req_corner0_x,
   input  logic signed [23:0] req_corner0_y,
   input  logic signed [23:0] req_corner1_x,
   input  logic signed [23:0] req_corner1_y,
   input  logic signed [23:0] req_corner2_x,
   input  logic signed [23:0] req_corner2_y,
   input  logic signed [23:0] req_corner3_x,
   input  logic signed [23:0] req_corner3_y,
   output logic               rsp_strobe,
   output logic               rsp_collided,
   input  logic               csr_we,
   input  logic [3:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   localparam int DEPTH = LAYERS * MAX_TILES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PT_W  = tmsc_pkg::PT_W;
   localparam int AX_W  = tmsc_pkg::AX_W;
   localparam int SUM_W = tmsc_pkg::SUM_W;
   localparam int RW    = tmsc_pkg::RW;
   localparam int TSW   = tmsc_pkg::TSW;
   localparam int CNT_W = tmsc_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_IDLE, S_BOUND, S_REJ, S_DIV, S_RANGE, S_BOX, S_TILE, S_DONE
   } state_type;

   logic signed [23:0] ox_ff, oy_ff;
   logic [22:0]        ew_ff, eh_ff;
   logic [TSW-1:0]     tw_ff, th_ff;
   logic [CNT_W-1:0]   cols_ff, rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ox_ff   <= '0;
         oy_ff   <= '0;
         ew_ff   <= '0;
         eh_ff   <= '0;
         tw_ff   <= TSW'(32);
         th_ff   <= TSW'(32);
         cols_ff <= CNT_W'(64);
         rows_ff <= CNT_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            tmsc_pkg::CSR_ORIGIN_X: ox_ff   <= csr_wdata;
            tmsc_pkg::CSR_ORIGIN_Y: oy_ff   <= csr_wdata;
            tmsc_pkg::CSR_EXTENT_W: ew_ff   <= csr_wdata[22:0];
            tmsc_pkg::CSR_EXTENT_H: eh_ff   <= csr_wdata[22:0];
            tmsc_pkg::CSR_TILE_W:   tw_ff   <= csr_wdata[TSW-1:0];
            tmsc_pkg::CSR_TILE_H:   th_ff   <= csr_wdata[TSW-1:0];
            tmsc_pkg::CSR_COLS:     cols_ff <= csr_wdata[CNT_W-1:0];
            tmsc_pkg::CSR_ROWS:     rows_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   state_type state_ff;
   logic [4:0] step_ff;
   logic       rsp_strobe_ff, rsp_collided_ff;
   logic       div_go_ff;
   logic [1:0] div_k_ff;

   logic signed [23:0] cx_ff [4];
   logic signed [23:0] cy_ff [4];
   logic signed [3:0]  layer_ff;
   logic signed [23:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic               xin_ff, yin_ff;
   logic [tmsc_pkg::QW-1:0] q_ff [4];
   logic [CNT_W-1:0]   row_ff, col_ff, mincol_ff, maxcol_ff, maxrow_ff;
   logic signed [AX_W-1:0] ax_ff [2];
   logic signed [AX_W-1:0] ay_ff [2];
   tmsc_pkg::prod_type acc_ff;
   tmsc_pkg::sum_type  cmin_ff [2];
   tmsc_pkg::sum_type  cmax_ff [2];
   logic [tmsc_pkg::ADR_W-1:0] addr_ff;
   logic               addr_ok_ff;
   logic signed [PT_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   tmsc_pkg::prod_type pr_ff [8];
   tmsc_pkg::sum_type  lo_ff [2];
   tmsc_pkg::sum_type  hi_ff [2];
   logic               sep_ff;

   logic [TSW-1:0]     tw_eff, th_eff;
   logic signed [23:0] bx, by;
   logic               layer_ok_req, idx_ok, wr_en;
   logic [AW-1:0]      waddr, raddr;
   logic [7:0]         rdata;
   logic signed [PT_W-1:0] mul_a;
   logic signed [AX_W-1:0] mul_b;
   tmsc_pkg::prod_type prod;
   tmsc_pkg::div_req_type div_req;
   logic               div_done;
   logic [tmsc_pkg::QW-1:0] div_quo;
   logic signed [24:0] rel;
   logic signed [23:0] mnx, mxx, mny, mxy;
   logic signed [24:0] rel_mx, rel_my;
   logic               reject;
   logic signed [RW-1:0] lim_c, lim_r, qmin_c, qmax_c, qmin_r, qmax_r, maxc, maxr;
   logic               empty;
   logic [4:0]         bp;
   tmsc_pkg::sum_type  psum;
   logic               apart;
   logic               last_col, last_row;
   tmsc_pkg::sum_type  lo_c [2];
   tmsc_pkg::sum_type  hi_c [2];

   assign tw_eff = (tw_ff == '0) ? TSW'(1) : tw_ff;
   assign th_eff = (th_ff == '0) ? TSW'(1) : th_ff;
   assign bx = {ox_ff[23:8], 8'd0} + ((ox_ff[23] && ox_ff[7:0] != 8'd0) ? 24'sd256 : 24'sd0);
   assign by = {oy_ff[23:8], 8'd0} + ((oy_ff[23] && oy_ff[7:0] != 8'd0) ? 24'sd256 : 24'sd0);

   assign busy = (state_ff != S_IDLE);
   assign layer_ok_req = !req_layer[3] && (32'(req_layer[2:0]) < LAYERS);
   assign idx_ok = 32'(req_tile_index) < MAX_TILES;
   assign wr_en  = start && !busy && (req_func == tmsc_pkg::FUNC_WRITE) && layer_ok_req && idx_ok;
   assign waddr  = AW'(32'(req_layer[2:0]) * MAX_TILES + 32'(req_tile_index));
   assign raddr  = AW'(32'(layer_ff[2:0]) * MAX_TILES + 32'(addr_ff));

   tmsc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (waddr),
      .wdata (req_tile_code),
      .raddr (raddr),
      .rdata (rdata)
   );

   tmsc_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   always_comb begin
      case (div_k_ff)
         2'd0:    rel = 25'(minx_ff) - 25'(ox_ff);
         2'd1:    rel = 25'(maxx_ff) - 25'(ox_ff);
         2'd2:    rel = 25'(miny_ff) - 25'(oy_ff);
         default: rel = 25'(maxy_ff) - 25'(oy_ff);
      endcase
      div_req.go       = div_go_ff;
      div_req.dividend = rel[24] ? '0 : rel[24:8];
      div_req.divisor  = div_k_ff[1] ? th_eff : tw_eff;
   end

   tmsc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      mnx = cx_ff[0]; mxx = cx_ff[0]; mny = cy_ff[0]; mxy = cy_ff[0];
      for (int k = 1; k < 4; k++) begin
         if (cx_ff[k] < mnx) mnx = cx_ff[k];
         if (cx_ff[k] > mxx) mxx = cx_ff[k];
         if (cy_ff[k] < mny) mny = cy_ff[k];
         if (cy_ff[k] > mxy) mxy = cy_ff[k];
      end
   end

   always_comb begin
      rel_mx = 25'(maxx_ff) - 25'(ox_ff);
      rel_my = 25'(maxy_ff) - 25'(oy_ff);
      reject = (25'(maxy_ff) < 25'(oy_ff)) ||
               (25'(miny_ff) > 25'(oy_ff) + $signed({2'b00, eh_ff})) ||
               (25'(maxx_ff) < 25'(ox_ff)) ||
               (25'(minx_ff) > 25'(ox_ff) + $signed({2'b00, ew_ff}));
   end

   always_comb begin
      lim_c  = RW'($signed({1'b0, cols_ff})) - RW'(1);
      lim_r  = RW'($signed({1'b0, rows_ff})) - RW'(1);
      qmin_c = $signed({1'b0, q_ff[0]});
      qmax_c = $signed({1'b0, q_ff[1]});
      qmin_r = $signed({1'b0, q_ff[2]});
      qmax_r = $signed({1'b0, q_ff[3]});
      maxc   = (xin_ff && qmax_c <= lim_c) ? qmax_c : lim_c;
      maxr   = (yin_ff && qmax_r <= lim_r) ? qmax_r : lim_r;
      empty  = (qmin_c > maxc) || (qmin_r > maxr);
   end

   always_comb begin
      bp   = step_ff - 5'd1;
      psum = SUM_W'(acc_ff) + SUM_W'(prod);
      for (int j = 0; j < 2; j++) begin
         lo_c[j] = ((pr_ff[4*j] < pr_ff[4*j+1]) ? SUM_W'(pr_ff[4*j]) : SUM_W'(pr_ff[4*j+1])) +
                   ((pr_ff[4*j+2] < pr_ff[4*j+3]) ? SUM_W'(pr_ff[4*j+2]) :
                                                     SUM_W'(pr_ff[4*j+3]));
         hi_c[j] = ((pr_ff[4*j] > pr_ff[4*j+1]) ? SUM_W'(pr_ff[4*j]) : SUM_W'(pr_ff[4*j+1])) +
                   ((pr_ff[4*j+2] > pr_ff[4*j+3]) ? SUM_W'(pr_ff[4*j+2]) :
                                                     SUM_W'(pr_ff[4*j+3]));
      end
      apart = sep_ff ||
              (cmax_ff[0] < lo_ff[0]) || (cmin_ff[0] > hi_ff[0]) ||
              (cmax_ff[1] < lo_ff[1]) || (cmin_ff[1] > hi_ff[1]);
      last_col = (col_ff == maxcol_ff);
      last_row = (row_ff == maxrow_ff);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BOX: begin
            if (step_ff[0]) begin
               mul_a = PT_W'(cy_ff[step_ff[2:1]]);
               mul_b = ay_ff[step_ff[3]];
            end else begin
               mul_a = PT_W'(cx_ff[step_ff[2:1]]);
               mul_b = ax_ff[step_ff[3]];
            end
         end
         S_TILE: begin
            case (step_ff)
               5'd0: begin mul_a = PT_W'(row_ff); mul_b = AX_W'(cols_ff); end
               5'd1: begin mul_a = PT_W'(col_ff); mul_b = AX_W'(tw_eff); end
               5'd2: begin mul_a = PT_W'(row_ff); mul_b = AX_W'(th_eff); end
               5'd3: begin mul_a = x0_ff; mul_b = ax_ff[0]; end
               5'd4: begin mul_a = x1_ff; mul_b = ax_ff[0]; end
               5'd5: begin mul_a = y0_ff; mul_b = ay_ff[0]; end
               5'd6: begin mul_a = y1_ff; mul_b = ay_ff[0]; end
               5'd7: begin mul_a = x0_ff; mul_b = ax_ff[1]; end
               5'd8: begin mul_a = x1_ff; mul_b = ax_ff[1]; end
               5'd9: begin mul_a = y0_ff; mul_b = ay_ff[1]; end
               5'd10: begin mul_a = y1_ff; mul_b = ay_ff[1]; end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         step_ff         <= '0;
         rsp_strobe_ff   <= 1'b0;
         rsp_collided_ff <= 1'b0;
         div_go_ff       <= 1'b0;
         div_k_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         div_go_ff     <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start && req_func == tmsc_pkg::FUNC_QUERY) begin
                  cx_ff[0] <= req_corner0_x; cy_ff[0] <= req_corner0_y;
                  cx_ff[1] <= req_corner1_x; cy_ff[1] <= req_corner1_y;
                  cx_ff[2] <= req_corner2_x; cy_ff[2] <= req_corner2_y;
                  cx_ff[3] <= req_corner3_x; cy_ff[3] <= req_corner3_y;
                  layer_ff <= req_layer;
                  state_ff <= S_BOUND;
               end
            end
            S_BOUND: begin
               minx_ff  <= mnx;
               maxx_ff  <= mxx;
               miny_ff  <= mny;
               maxy_ff  <= mxy;
               state_ff <= S_REJ;
            end
            S_REJ: begin
               xin_ff <= rel_mx < $signed({2'b00, ew_ff});
               yin_ff <= rel_my < $signed({2'b00, eh_ff});
               if (reject) begin
                  rsp_collided_ff <= 1'b0;
                  state_ff        <= S_DONE;
               end else begin
                  div_go_ff <= 1'b1;
                  div_k_ff  <= '0;
                  state_ff  <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  q_ff[div_k_ff] <= div_quo;
                  if (div_k_ff == 2'd3) begin
                     state_ff <= S_RANGE;
                  end else begin
                     div_k_ff  <= div_k_ff + 2'd1;
                     div_go_ff <= 1'b1;
                  end
               end
            end
            S_RANGE: begin
               ax_ff[0]  <= 25'(cx_ff[0]) - 25'(cx_ff[1]);
               ay_ff[0]  <= 25'(cy_ff[0]) - 25'(cy_ff[1]);
               ax_ff[1]  <= 25'(cx_ff[1]) - 25'(cx_ff[2]);
               ay_ff[1]  <= 25'(cy_ff[1]) - 25'(cy_ff[2]);
               mincol_ff <= qmin_c[CNT_W-1:0];
               col_ff    <= qmin_c[CNT_W-1:0];
               row_ff    <= qmin_r[CNT_W-1:0];
               maxcol_ff <= maxc[CNT_W-1:0];
               maxrow_ff <= maxr[CNT_W-1:0];
               step_ff   <= '0;
               if (empty) begin
                  rsp_collided_ff <= 1'b0;
                  state_ff        <= S_DONE;
               end else begin
                  state_ff <= S_BOX;
               end
            end
            S_BOX: begin
               if (step_ff != 5'd0) begin
                  if (!bp[0]) begin
                     acc_ff <= prod;
                  end else if (bp[2:1] == 2'd0) begin
                     cmin_ff[bp[3]] <= psum;
                     cmax_ff[bp[3]] <= psum;
                  end else begin
                     if (psum < cmin_ff[bp[3]]) cmin_ff[bp[3]] <= psum;
                     if (psum > cmax_ff[bp[3]]) cmax_ff[bp[3]] <= psum;
                  end
               end
               if (step_ff == 5'd16) begin
                  step_ff  <= '0;
                  state_ff <= S_TILE;
               end else begin
                  step_ff <= step_ff + 5'd1;
               end
            end
            S_TILE: begin
               step_ff <= step_ff + 5'd1;
               case (step_ff)
                  5'd1: addr_ff <= tmsc_pkg::ADR_W'(prod) + tmsc_pkg::ADR_W'(col_ff);
                  5'd2: begin
                     x0_ff      <= PT_W'(bx) + {prod[PT_W-9:0], 8'd0};
                     addr_ok_ff <= !layer_ff[3] && (32'(layer_ff[2:0]) < LAYERS) &&
                                   (32'(addr_ff) < MAX_TILES);
                  end
                  5'd3: begin
                     y0_ff <= PT_W'(by) + {prod[PT_W-9:0], 8'd0};
                     x1_ff <= x0_ff + PT_W'({tw_eff, 8'd0});
                  end
                  5'd4: y1_ff <= y0_ff + PT_W'({th_eff, 8'd0});
                  5'd12: begin
                     lo_ff[0] <= lo_c[0];
                     lo_ff[1] <= lo_c[1];
                     hi_ff[0] <= hi_c[0];
                     hi_ff[1] <= hi_c[1];
                     sep_ff   <= (PT_W'(minx_ff) > x1_ff) || (PT_W'(maxx_ff) < x0_ff) ||
                                 (PT_W'(maxy_ff) < y0_ff) || (PT_W'(miny_ff) > y1_ff);
                  end
                  default: ;
               endcase
               if (step_ff >= 5'd4 && step_ff <= 5'd11) begin
                  pr_ff[3'(step_ff - 5'd4)] <= prod;
               end
               if ((step_ff == 5'd3 && addr_ok_ff && rdata == tmsc_pkg::CODE_WALKABLE) ||
                   (step_ff == 5'd13 && apart)) begin
                  step_ff <= '0;
                  if (last_col) begin
                     col_ff <= mincol_ff;
                     row_ff <= row_ff + CNT_W'(1);
                     if (last_row) begin
                        rsp_collided_ff <= 1'b0;
                        state_ff        <= S_DONE;
                     end
                  end else begin
                     col_ff <= col_ff + CNT_W'(1);
                  end
               end else if (step_ff == 5'd13) begin
                  rsp_collided_ff <= 1'b1;
                  state_ff        <= S_DONE;
               end
            end
            S_DONE: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_collided = rsp_collided_ff;
endmodule

### sv/tmsc_checker.sv
`include "assert_macros.svh"

module tmsc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_strobe
);
   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_NEXT(a_query_busy, clock, reset, start && !busy && req_func, busy)
   `ASSERT_NEXT(a_write_quiet, clock, reset, start && !busy && !req_func, !busy && !rsp_strobe)
   `ASSERT_IMPLY(a_end_strobe, clock, reset, $fell(busy), rsp_strobe)
   `ASSERT_NEXT(a_strobe_once, clock, reset, rsp_strobe, !rsp_strobe)
endmodule

bind tile_map_sat_collision_top tmsc_checker u_tmsc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_func   (req_func),
   .rsp_strobe (rsp_strobe)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   typedef struct packed {
      logic             func;
      logic [3:0]       layer;
      logic [11:0]      tidx;
      logic [7:0]       code;
      logic [3:0][23:0] px;
      logic [3:0][23:0] py;
   } tile_op_type;

   localparam int NTILES = 4096;
   localparam int NLAYERS = 4;
   // every map keeps cols * rows within this many tiles
   localparam int PREFILL_TILES = 64;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_func = 1'b0;
   logic signed [3:0]  req_layer = '0;
   logic [11:0]        req_tile_index = '0;
   logic [7:0]         req_tile_code = '0;
   logic signed [23:0] req_corner0_x = '0, req_corner0_y = '0;
   logic signed [23:0] req_corner1_x = '0, req_corner1_y = '0;
   logic signed [23:0] req_corner2_x = '0, req_corner2_y = '0;
   logic signed [23:0] req_corner3_x = '0, req_corner3_y = '0;
   logic               rsp_strobe;
   logic               rsp_collided;
   logic               csr_we = 1'b0;
   logic [3:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;

   tile_map_sat_collision_top dut (.*);

   always #6 clock = ~clock;

   longint      m_ox, m_oy, m_ew, m_eh, m_tw, m_th, m_cols, m_rows;
   bit [7:0]    tile_mem [NTILES*NLAYERS];
   tile_op_type pending_ops [$];
   bit          collide_q [$];
   tile_op_type held;
   int          send_idle = 11;
   int          errors = 0;
   int          queries_seen = 0;
   int          hits_seen = 0;
   int          writes_done = 0;

   function automatic longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint srand(longint m);
      return longint'($urandom_range(0, int'(2 * m))) - m;
   endfunction

   function automatic void proj(input longint xs[4], input longint ys[4],
                                input longint ax, input longint ay,
                                output longint lo, output longint hi);
      longint p;
      lo = xs[0] * ax + ys[0] * ay;
      hi = lo;
      for (int k = 1; k < 4; k++) begin
         p = xs[k] * ax + ys[k] * ay;
         if (p < lo) lo = p;
         if (p > hi) hi = p;
      end
   endfunction

   function automatic bit predict_collision(tile_op_type op);
      longint cx[4], cy[4], ax[4], ay[4], cmin[4], cmax[4], tx[4], ty[4];
      longint minx, maxx, miny, maxy, tw, th, rel, lay;
      longint mincol, maxcol, minrow, maxrow, bx, by, adr, x0, x1, y0, y1, lo, hi;
      bit [7:0] code;
      bit apart;
      lay = longint'($signed(op.layer));
      for (int k = 0; k < 4; k++) begin
         cx[k] = longint'($signed(op.px[k]));
         cy[k] = longint'($signed(op.py[k]));
      end
      minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
      for (int k = 1; k < 4; k++) begin
         if (cx[k] < minx) minx = cx[k];
         if (cx[k] > maxx) maxx = cx[k];
         if (cy[k] < miny) miny = cy[k];
         if (cy[k] > maxy) maxy = cy[k];
      end
      if (maxy < m_oy || miny > m_oy + m_eh || maxx < m_ox || minx > m_ox + m_ew)
         return 1'b0;
      tw = (m_tw != 0) ? m_tw : 1;
      th = (m_th != 0) ? m_th : 1;
      rel = minx - m_ox;
      mincol = (rel > 0) ? (rel / 256) / tw : 0;
      rel = maxx - m_ox;
      maxcol = (rel < m_ew) ? (rel / 256) / tw : m_cols - 1;
      if (maxcol > m_cols - 1) maxcol = m_cols - 1;
      rel = miny - m_oy;
      minrow = (rel > 0) ? (rel / 256) / th : 0;
      rel = maxy - m_oy;
      maxrow = (rel < m_eh) ? (rel / 256) / th : m_rows - 1;
      if (maxrow > m_rows - 1) maxrow = m_rows - 1;
      ax[0] = cx[0] - cx[1]; ay[0] = cy[0] - cy[1];
      ax[1] = cx[1] - cx[2]; ay[1] = cy[1] - cy[2];
      ax[2] = -1; ay[2] = 0;
      ax[3] = 0;  ay[3] = 1;
      for (int k = 0; k < 4; k++) proj(cx, cy, ax[k], ay[k], cmin[k], cmax[k]);
      bx = (m_ox / 256) * 256;
      by = (m_oy / 256) * 256;
      for (longint r = minrow; r <= maxrow; r++) begin
         for (longint c = mincol; c <= maxcol; c++) begin
            adr = r * m_cols + c;
            code = 8'd0;
            if (lay >= 0 && lay < NLAYERS && adr < NTILES)
               code = tile_mem[lay * NTILES + adr];
            if (code != tmsc_pkg::CODE_WALKABLE) begin
               x0 = bx + c * tw * 256; x1 = x0 + tw * 256;
               y0 = by + r * th * 256; y1 = y0 + th * 256;
               tx[0] = x0; ty[0] = y1;
               tx[1] = x1; ty[1] = y1;
               tx[2] = x1; ty[2] = y0;
               tx[3] = x0; ty[3] = y0;
               apart = 1'b0;
               for (int k = 0; k < 4; k++) begin
                  proj(tx, ty, ax[k], ay[k], lo, hi);
                  if (cmax[k] < lo || cmin[k] > hi) apart = 1'b1;
               end
               if (!apart) return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic void apply_op(tile_op_type op);
      longint lay;
      lay = longint'($signed(op.layer));
      if (op.func == tmsc_pkg::FUNC_WRITE) begin
         if (lay >= 0 && lay < NLAYERS && op.tidx < NTILES)
            tile_mem[lay * NTILES + op.tidx] = op.code;
         writes_done++;
      end else begin
         collide_q = {collide_q, predict_collision(op)};
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_op(held);
         if (!start || !busy) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               held = pending_ops.pop_front();
               start <= 1'b1;
               req_func <= held.func;
               req_layer <= held.layer;
               req_tile_index <= held.tidx;
               req_tile_code <= held.code;
               req_corner0_x <= held.px[0]; req_corner0_y <= held.py[0];
               req_corner1_x <= held.px[1]; req_corner1_y <= held.py[1];
               req_corner2_x <= held.px[2]; req_corner2_y <= held.py[2];
               req_corner3_x <= held.px[3]; req_corner3_y <= held.py[3];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (collide_q.size() == 0) begin
            $display("%0t unexpected result: expected none actual collided=%0b",
                     $time, rsp_collided);
            errors++;
         end else begin
            bit e;
            e = collide_q.pop_front();
            queries_seen++;
            if (rsp_collided) hits_seen++;
            if (rsp_collided !== e) begin
               $display("%0t collided mismatch: expected %0b actual %0b",
                        $time, e, rsp_collided);
               errors++;
            end
         end
      end
   end

   function automatic void append_op(tile_op_type op);
      pending_ops = {pending_ops, op};
   endfunction

   function automatic tile_op_type write_op(logic [3:0] lay, logic [11:0] idx, logic [7:0] code);
      tile_op_type op;
      op = '0;
      op.func = tmsc_pkg::FUNC_WRITE;
      op.layer = lay;
      op.tidx = idx;
      op.code = code;
      return op;
   endfunction

   function automatic tile_op_type box_op(logic [3:0] lay, longint xc, longint yc,
                                          longint ux, longint uy, longint vx, longint vy);
      tile_op_type op;
      op = '0;
      op.func = tmsc_pkg::FUNC_QUERY;
      op.layer = lay;
      op.tidx = 12'($urandom);
      op.code = 8'($urandom);
      op.px[0] = 24'(sat24(xc + ux + vx)); op.py[0] = 24'(sat24(yc + uy + vy));
      op.px[1] = 24'(sat24(xc - ux + vx)); op.py[1] = 24'(sat24(yc - uy + vy));
      op.px[2] = 24'(sat24(xc - ux - vx)); op.py[2] = 24'(sat24(yc - uy - vy));
      op.px[3] = 24'(sat24(xc + ux - vx)); op.py[3] = 24'(sat24(yc + uy - vy));
      return op;
   endfunction

   function automatic logic [7:0] rand_code();
      if ($urandom_range(0, 99) < 65) return tmsc_pkg::CODE_WALKABLE;
      return 8'($urandom);
   endfunction

   function automatic logic [3:0] rand_layer();
      if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, NLAYERS - 1));
      return 4'($urandom);
   endfunction

   task automatic program_map(longint ox, longint oy, longint ew, longint eh,
                              longint tw, longint th, longint cols, longint rows);
      logic [3:0]  idx [8];
      longint      val [8];
      idx = '{tmsc_pkg::CSR_ORIGIN_X, tmsc_pkg::CSR_ORIGIN_Y, tmsc_pkg::CSR_EXTENT_W,
              tmsc_pkg::CSR_EXTENT_H, tmsc_pkg::CSR_TILE_W, tmsc_pkg::CSR_TILE_H,
              tmsc_pkg::CSR_COLS, tmsc_pkg::CSR_ROWS};
      val = '{ox, oy, ew, eh, tw, th, cols, rows};
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= 24'(val[i]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
      m_ox = ox; m_oy = oy; m_ew = ew; m_eh = eh;
      m_tw = tw; m_th = th; m_cols = cols; m_rows = rows;
   endtask

   task automatic drain();
      while (pending_ops.size() > 0 || start || collide_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic select_map(int n);
      case (n)
         0: program_map(0, 0, 8*32*256, 8*32*256, 32, 32, 8, 8);
         1: program_map(-256128, 777, 7*256, 15*256, 1, 3, 7, 5);
         2: program_map(-8388608, -8388608, 8388607, 8388607, 1024, 1024, 1, 1);
         3: program_map(8388607, 1000, 0, 0, 0, 1, 8, 8);
         default: program_map(5000*256, -3000*256, 8*16*256 - 77, 8*8*256, 16, 8, 8, 8);
      endcase
   endtask

   task automatic queue_random(int count);
      longint tq, thq, xc, yc, ux, uy, r;
      tile_op_type op;
      tq = ((m_tw != 0) ? m_tw : 1) * 256;
      thq = ((m_th != 0) ? m_th : 1) * 256;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 25) begin
            append_op(write_op(rand_layer(), 12'($urandom), rand_code()));
         end else begin
            xc = m_ox + longint'($urandom_range(0, int'((m_cols + 4) * tq))) - 2 * tq;
            yc = m_oy + longint'($urandom_range(0, int'((m_rows + 4) * thq))) - 2 * thq;
            if ($urandom_range(0, 99) < 85) begin
               ux = srand(tq + tq * longint'($urandom_range(0, 1)));
               uy = srand(thq);
               r = longint'($urandom_range(0, 8));
               op = box_op(rand_layer(), xc, yc, ux, uy, -uy * r / 4, ux * r / 4);
            end else begin
               op = box_op(rand_layer(), xc, yc, 0, 0, 0, 0);
               for (int k = 0; k < 4; k++) begin
                  op.px[k] = 24'(sat24(xc + srand(2 * tq)));
                  op.py[k] = 24'(sat24(yc + srand(2 * thq)));
               end
            end
            append_op(op);
         end
      end
   endtask

   initial begin
      tile_op_type op;
      m_ox = 0; m_oy = 0; m_ew = 0; m_eh = 0;
      m_tw = 32; m_th = 32; m_cols = 64; m_rows = 64;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int l = 0; l < NLAYERS; l++)
         for (int i = 0; i < PREFILL_TILES; i++)
            append_op(write_op(4'(l), 12'(i), rand_code()));
      drain();
      select_map(0);

      append_op(write_op(4'd0, 12'd0, 8'd0));
      append_op(write_op(4'd0, 12'd1, tmsc_pkg::CODE_WALKABLE));
      append_op(write_op(4'd3, 12'd4095, 8'hFF));
      append_op(write_op(4'sd7, 12'd5, 8'hAA));
      append_op(write_op(-4'sd8, 12'd6, 8'h55));
      append_op(box_op(4'd0, 16*256, 16*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'd0, 48*256, 16*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'd0, 40*256, 20*256, 3*256, 2*256, -2*256, 3*256));
      append_op(box_op(4'd0, 40*256, 20*256, 0, 0, 0, 0));
      append_op(box_op(4'd1, 40*256, 20*256, 5*256, 0, 0, 0));
      append_op(box_op(4'd0, -50*256, 10*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'd0, 10*256, 9000*256, 4*256, 0, 0, 4*256));
      append_op(box_op(-4'sd8, 40*256, 20*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'sd7, 40*256, 20*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'd4, 40*256, 20*256, 4*256, 0, 0, 4*256));
      append_op(box_op(4'd3, 2047*256, 2047*256, 3*256, 3*256, 0, 0));
      append_op(box_op(-4'sd1, 0, 0, 8388607, 8388607, -8388607, 8388607));
      drain();
      select_map(2);
      op = box_op(4'd0, 0, 0, 0, 0, 0, 0);
      op.px = {24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000};
      op.py = {24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000};
      append_op(op);
      append_op(box_op(4'd2, -8388608, -8388608, 0, 0, 0, 0));
      append_op(box_op(4'd2, 8388607, 8388607, 0, 0, 0, 0));
      drain();

      for (int p = 0; p < 3; p++) begin
         send_idle = (p == 0) ? 11 : (p == 1) ? 78 : 0;
         for (int c = 0; c < 5; c++) begin
            select_map(c);
            queue_random(30);
            drain();
            queue_random(30);
            drain();
         end
      end

      $display("covered %0d queries (%0d collisions) and %0d tile writes over five map setups",
               queries_seen, hits_seen, writes_done);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule

### files.f
+incdir+sv
sv/tmsc_pkg.sv
sv/tmsc_ram.sv
sv/tmsc_mul.sv
sv/tmsc_div.sv
sv/tile_map_sat_collision_top.sv
sv/tmsc_checker.sv
tb/tb_top.sv
